>>> design/motor_speed_map_soft_start_macros.svh
// ----------------------------------------------------------------------------
// Motor speed map assertion macros
// Shorthand for the concurrent checks of the motor speed map block.
// The macros expect clk and arst_n in scope.
// ----------------------------------------------------------------------------
`ifndef MOTOR_SPEED_MAP_SOFT_START_MACROS_SVH
`define MOTOR_SPEED_MAP_SOFT_START_MACROS_SVH

// Check that the consequent holds in the same cycle as the antecedent
`define MSMSS_CHK_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("msmss: same-cycle check failed");

// Check that the consequent holds in the cycle after the antecedent
`define MSMSS_CHK_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("msmss: next-cycle check failed");

`endif

>>> design/msmss_pkg.sv
// ----------------------------------------------------------------------------
// Motor speed map package
// Beat types, register indexes, reset values and command codes shared by the
// front end, the back end and the top level.
// ----------------------------------------------------------------------------
package msmss_pkg;

	localparam int DUTY_W = 8;
	localparam int SMP_W  = 8;
	localparam int PROD_W = 2 * DUTY_W;
	localparam int IDX_W  = 3;
	localparam int Q_DEPTH = 2;

	// Register indexes
	localparam logic [IDX_W-1:0] CFG_OFF_THRESHOLD = 3'd0;
	localparam logic [IDX_W-1:0] CFG_POT_LOW       = 3'd1;
	localparam logic [IDX_W-1:0] CFG_POT_HIGH      = 3'd2;
	localparam logic [IDX_W-1:0] CFG_PWM_LOW       = 3'd3;
	localparam logic [IDX_W-1:0] CFG_PWM_HIGH      = 3'd4;

	// Register reset values
	localparam logic [DUTY_W-1:0] RST_OFF_THRESHOLD = 8'd10;
	localparam logic [DUTY_W-1:0] RST_POT_LOW       = 8'd70;
	localparam logic [DUTY_W-1:0] RST_POT_HIGH      = 8'd235;
	localparam logic [DUTY_W-1:0] RST_PWM_LOW       = 8'd1;
	localparam logic [DUTY_W-1:0] RST_PWM_HIGH      = 8'd255;

	// Input beat
	typedef struct packed {
		logic              action;
		logic [SMP_W-1:0]  sample;
		logic              jumper_closed;
	} msmss_in_t;

	// Result beat
	typedef struct packed {
		logic [DUTY_W-1:0] duty;
		logic              led_direct;
		logic              led_inverted;
		logic              at_target;
	} msmss_out_t;

	// Command class decided by the front end
	typedef enum logic [1:0] {
		CMD_TICK,
		CMD_OFF,
		CMD_FLAT,
		CMD_MAP
	} msmss_kind_t;

	// Classified command handed to the back end
	typedef struct packed {
		msmss_kind_t       kind;
		logic              inverted;
		logic              down;
		logic [DUTY_W-1:0] base;
		logic [DUTY_W-1:0] offset;
		logic [DUTY_W-1:0] diff;
		logic [DUTY_W-1:0] span;
	} msmss_cmd_t;

	// Back end status
	typedef struct packed {
		logic busy;
		logic res_push;
	} msmss_bk_stat_t;

endpackage

>>> design/msmss_front.sv
// ----------------------------------------------------------------------------
// Motor speed map front end
// Holds the configuration registers, classifies each accepted beat into a
// command with its map operands, and buffers commands for the back end.
// ----------------------------------------------------------------------------
module msmss_front #(
	parameter int SAMPLE_BITS = 8
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [msmss_pkg::IDX_W-1:0]          cfg_idx,
	input  logic [msmss_pkg::DUTY_W-1:0]         cfg_data,
	input  logic                                 push,
	output logic                                 full,
	input  msmss_pkg::msmss_in_t                 item,
	output logic                                 cmd_valid,
	output msmss_pkg::msmss_cmd_t                cmd,
	input  logic                                 cmd_take
);

	localparam int DW        = msmss_pkg::DUTY_W;
	localparam int SW        = msmss_pkg::SMP_W;
	localparam int KEEP_BITS = (SAMPLE_BITS < SW) ? SAMPLE_BITS : SW;
	localparam logic [SW-1:0] SAMPLE_MASK = SW'((64'd1 << KEEP_BITS) - 64'd1);
	localparam int DEPTH     = msmss_pkg::Q_DEPTH;
	localparam int PTR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W     = $clog2(DEPTH + 1);

	logic [DW-1:0] off_thr_q, pot_low_q, pot_high_q, pwm_low_q, pwm_high_q;

	logic [SW-1:0]         smp;
	logic [DW-1:0]         x_clamp;
	logic [DW-1:0]         map_from, map_to;
	logic                  win_empty;
	msmss_pkg::msmss_cmd_t cls;

	msmss_pkg::msmss_cmd_t cq_mem_q [DEPTH];
	logic [PTR_W-1:0]      wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  do_push, do_take;

	// Configuration registers; unknown indexes drop the write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_thr_q  <= msmss_pkg::RST_OFF_THRESHOLD;
			pot_low_q  <= msmss_pkg::RST_POT_LOW;
			pot_high_q <= msmss_pkg::RST_POT_HIGH;
			pwm_low_q  <= msmss_pkg::RST_PWM_LOW;
			pwm_high_q <= msmss_pkg::RST_PWM_HIGH;
		end else if (cfg_we) begin
			case (cfg_idx)
				msmss_pkg::CFG_OFF_THRESHOLD: off_thr_q  <= cfg_data;
				msmss_pkg::CFG_POT_LOW:       pot_low_q  <= cfg_data;
				msmss_pkg::CFG_POT_HIGH:      pot_high_q <= cfg_data;
				msmss_pkg::CFG_PWM_LOW:       pwm_low_q  <= cfg_data;
				msmss_pkg::CFG_PWM_HIGH:      pwm_high_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Classify the incoming beat and prepare the map operands
	always_comb begin
		smp       = item.sample & SAMPLE_MASK;
		win_empty = (pot_high_q <= pot_low_q);
		if (smp >= pot_high_q) begin
			x_clamp = pot_high_q;
		end else if (smp <= pot_low_q) begin
			x_clamp = pot_low_q;
		end else begin
			x_clamp = smp;
		end
		if (item.jumper_closed) begin
			map_from = pwm_high_q;
			map_to   = pwm_low_q;
		end else begin
			map_from = pwm_low_q;
			map_to   = pwm_high_q;
		end
		cls.inverted = item.jumper_closed;
		cls.down     = (map_to < map_from);
		cls.diff     = cls.down ? (map_from - map_to) : (map_to - map_from);
		cls.offset   = x_clamp - pot_low_q;
		cls.span     = pot_high_q - pot_low_q;
		cls.base     = win_empty ? pwm_low_q : map_from;
		if (item.action) begin
			cls.kind = msmss_pkg::CMD_TICK;
		end else if (smp <= off_thr_q) begin
			cls.kind = msmss_pkg::CMD_OFF;
		end else if (win_empty) begin
			cls.kind = msmss_pkg::CMD_FLAT;
		end else begin
			cls.kind = msmss_pkg::CMD_MAP;
		end
	end

	// Command queue toward the back end
	assign full      = (cnt_q == CNT_W'(DEPTH));
	assign cmd_valid = (cnt_q != '0);
	assign cmd       = cq_mem_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_take   = cmd_take && cmd_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_take) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_take) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!do_push && do_take) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// Store the classified beat
	always_ff @(posedge clk) begin
		if (do_push) begin
			cq_mem_q[wr_ptr_q] <= cls;
		end
	end

endmodule

>>> design/msmss_div.sv
// ----------------------------------------------------------------------------
// Motor speed map divider
// Restoring divider: one quotient bit per cycle over the product width.
// The quotient of the map is known to fit the duty width.
// ----------------------------------------------------------------------------
module msmss_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [msmss_pkg::PROD_W-1:0]  dividend,
	input  logic [msmss_pkg::DUTY_W-1:0]  divisor,
	output logic                          done,
	output logic [msmss_pkg::DUTY_W-1:0]  quotient
);

	localparam int DW    = msmss_pkg::DUTY_W;
	localparam int PW    = msmss_pkg::PROD_W;
	localparam int CNT_W = $clog2(PW + 1);

	logic             busy_q, done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DW-1:0]    rem_q;
	logic [PW-1:0]    quo_q;

	logic [DW:0]      trial, trial_sub;
	logic             ge;
	logic [DW-1:0]    rem_nxt;

	// One restoring step
	always_comb begin
		trial     = {rem_q, quo_q[PW-1]};
		trial_sub = trial - {1'b0, divisor};
		ge        = (trial >= {1'b0, divisor});
		rem_nxt   = ge ? trial_sub[DW-1:0] : trial[DW-1:0];
	end

	// Step counter and completion flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(PW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// Shift in quotient bits
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= rem_nxt;
			quo_q <= {quo_q[PW-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q[DW-1:0];

endmodule

>>> design/msmss_back.sv
// ----------------------------------------------------------------------------
// Motor speed map back end
// Carries out commands: ramp ticks, stop and flat targets, and the linear map
// through a registered multiply and the serial divider. Results wait in a
// small queue toward the result side.
// ----------------------------------------------------------------------------
module msmss_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cmd_valid,
	input  msmss_pkg::msmss_cmd_t      cmd,
	output logic                       cmd_take,
	output logic                       empty,
	input  logic                       pop,
	output msmss_pkg::msmss_out_t      result,
	output msmss_pkg::msmss_bk_stat_t  stat
);

	localparam int DW    = msmss_pkg::DUTY_W;
	localparam int PW    = msmss_pkg::PROD_W;
	localparam int DEPTH = msmss_pkg::Q_DEPTH;
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV
	} state_t;

	state_t                state_q;
	logic [DW-1:0]         target_q, ramp_q;
	logic                  led_dir_q, led_inv_q;
	msmss_pkg::msmss_cmd_t cur_q;
	logic [PW-1:0]         prod_q;

	logic                  div_start, div_done;
	logic [DW-1:0]         div_quo;
	logic [DW-1:0]         ramp_next, map_target;

	logic                  res_push;
	msmss_pkg::msmss_out_t res_data;

	msmss_pkg::msmss_out_t oq_mem_q [DEPTH];
	logic [PTR_W-1:0]      oq_wr_q, oq_rd_q;
	logic [CNT_W-1:0]      oq_cnt_q;
	logic                  oq_full, oq_pop;

	msmss_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (prod_q),
		.divisor  (cur_q.span),
		.done     (div_done),
		.quotient (div_quo)
	);

	// Ramp step and map result
	always_comb begin
		if (ramp_q < target_q) begin
			ramp_next = ramp_q + 1'b1;
		end else if (ramp_q > target_q) begin
			ramp_next = ramp_q - 1'b1;
		end else begin
			ramp_next = ramp_q;
		end
		map_target = cur_q.down ? (cur_q.base - div_quo) : (cur_q.base + div_quo);
	end

	assign cmd_take  = (state_q == ST_IDLE) && cmd_valid && !oq_full;
	assign div_start = (state_q == ST_MUL);

	// Build the result beat
	always_comb begin
		res_push = 1'b0;
		res_data = '0;
		case (state_q)
			ST_IDLE: begin
				if (cmd_take) begin
					case (cmd.kind)
						msmss_pkg::CMD_TICK: begin
							res_push = 1'b1;
							res_data = '{duty: ramp_next, led_direct: led_dir_q,
								led_inverted: led_inv_q, at_target: (ramp_next == target_q)};
						end
						msmss_pkg::CMD_OFF: begin
							res_push = 1'b1;
							res_data = '{duty: ramp_q, led_direct: 1'b0,
								led_inverted: 1'b0, at_target: (ramp_q == '0)};
						end
						msmss_pkg::CMD_FLAT: begin
							res_push = 1'b1;
							res_data = '{duty: ramp_q, led_direct: !cmd.inverted,
								led_inverted: cmd.inverted, at_target: (ramp_q == cmd.base)};
						end
						default: ;
					endcase
				end
			end
			ST_DIV: begin
				if (div_done) begin
					res_push = 1'b1;
					res_data = '{duty: ramp_q, led_direct: !cur_q.inverted,
						led_inverted: cur_q.inverted, at_target: (ramp_q == map_target)};
				end
			end
			default: ;
		endcase
	end

	// Sequencer and block state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			target_q  <= '0;
			ramp_q    <= '0;
			led_dir_q <= 1'b0;
			led_inv_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd_take) begin
						case (cmd.kind)
							msmss_pkg::CMD_TICK: begin
								ramp_q <= ramp_next;
							end
							msmss_pkg::CMD_OFF: begin
								target_q  <= '0;
								led_dir_q <= 1'b0;
								led_inv_q <= 1'b0;
							end
							msmss_pkg::CMD_FLAT: begin
								target_q  <= cmd.base;
								led_dir_q <= !cmd.inverted;
								led_inv_q <= cmd.inverted;
							end
							msmss_pkg::CMD_MAP: begin
								state_q <= ST_MUL;
							end
							default: ;
						endcase
					end
				end
				ST_MUL: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_done) begin
						target_q  <= map_target;
						led_dir_q <= !cur_q.inverted;
						led_inv_q <= cur_q.inverted;
						state_q   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Latch each taken command and register its product
	always_ff @(posedge clk) begin
		if (cmd_take) begin
			cur_q  <= cmd;
			prod_q <= PW'(cmd.offset) * PW'(cmd.diff);
		end
	end

	// Result queue
	assign oq_full = (oq_cnt_q == CNT_W'(DEPTH));
	assign empty   = (oq_cnt_q == '0);
	assign oq_pop  = pop && !empty;
	assign result  = oq_mem_q[oq_rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oq_wr_q  <= '0;
			oq_rd_q  <= '0;
			oq_cnt_q <= '0;
		end else begin
			if (res_push) begin
				oq_wr_q <= oq_wr_q + 1'b1;
			end
			if (oq_pop) begin
				oq_rd_q <= oq_rd_q + 1'b1;
			end
			if (res_push && !oq_pop) begin
				oq_cnt_q <= oq_cnt_q + 1'b1;
			end else if (!res_push && oq_pop) begin
				oq_cnt_q <= oq_cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_push) begin
			oq_mem_q[oq_wr_q] <= res_data;
		end
	end

	assign stat.busy     = (state_q != ST_IDLE);
	assign stat.res_push = res_push;

endmodule

>>> design/motor_speed_map_soft_start.sv
// ----------------------------------------------------------------------------
// Motor speed map with soft start
// Turns potentiometer samples into a PWM duty target and ramps the output
// duty toward it by one step per millisecond tick. Each accepted beat, sample
// or tick, yields exactly one result beat holding the duty, the mode LEDs and
// an at-target flag. Beats enter a two-entry command queue at up to one per
// cycle while full is low. A tick, a stop sample and a sample with an empty
// pot window finish in the back end as soon as it takes them; a mapped sample
// holds it busy through the multiply state, the divider load, 16 divider
// steps and the result write, paced by the bit-serial divider. Results wait
// in a two-entry queue until popped.
// ----------------------------------------------------------------------------
`include "motor_speed_map_soft_start_macros.svh"

module motor_speed_map_soft_start #(
	parameter int SAMPLE_BITS = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [msmss_pkg::IDX_W-1:0]   cfg_idx,
	input  logic [msmss_pkg::DUTY_W-1:0]  cfg_data,
	input  logic                          push,
	output logic                          full,
	input  msmss_pkg::msmss_in_t          item,
	output logic                          empty,
	input  logic                          pop,
	output msmss_pkg::msmss_out_t         result
);

	logic                      cmd_valid, cmd_take;
	msmss_pkg::msmss_cmd_t     cmd;
	msmss_pkg::msmss_bk_stat_t bk_stat;

	msmss_front #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_data  (cfg_data),
		.push      (push),
		.full      (full),
		.item      (item),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_take  (cmd_take)
	);

	msmss_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_take  (cmd_take),
		.empty     (empty),
		.pop       (pop),
		.result    (result),
		.stat      (bk_stat)
	);

	// Back end never takes a command that is not there
	`MSMSS_CHK_NOW(a_take_valid, cmd_take, cmd_valid)
	// A command is taken only while the back end is idle
	`MSMSS_CHK_NOW(a_take_idle, bk_stat.busy, !cmd_take)
	// A written result is visible on the result side next cycle
	`MSMSS_CHK_NEXT(a_push_visible, bk_stat.res_push, !empty)
	// A mapped sample occupies the back end
	`MSMSS_CHK_NEXT(a_map_busy, cmd_take && (cmd.kind == msmss_pkg::CMD_MAP), bk_stat.busy)

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Motor speed map testbench
// Drives samples and ramp ticks through the queue ports of the speed map,
// mirrors the register file and the ramp state in a local predictor, and
// compares every result beat with the predicted duty, mode LEDs and at-target
// flag. Sender bursts, receiver stalls and a long receiver hold-off vary the
// timing; register settings change between phases while the block is idle.
// ----------------------------------------------------------------------------
module testbench;

	localparam int   DW = msmss_pkg::DUTY_W;
	localparam int   SW = msmss_pkg::SMP_W;
	localparam int   IW = msmss_pkg::IDX_W;
	localparam logic ACT_SAMPLE = 1'b0;
	localparam logic ACT_TICK   = 1'b1;
	localparam int   IDLE_LIMIT = 2000;
	localparam int   HOLD_CYCLES = 300;

	logic                   clk;
	logic                   arst_n = 1'b0;
	logic                   cfg_we = 1'b0;
	logic [IW-1:0]          cfg_idx = '0;
	logic [DW-1:0]          cfg_data = '0;
	logic                   push = 1'b0;
	logic                   full;
	msmss_pkg::msmss_in_t   item = '0;
	logic                   empty;
	logic                   pop = 1'b0;
	msmss_pkg::msmss_out_t  result;

	// Register mirror
	logic [DW-1:0]  thresh_m;
	logic [DW-1:0]  pot_lo_m;
	logic [DW-1:0]  pot_hi_m;
	logic [DW-1:0]  pwm_lo_m;
	logic [DW-1:0]  pwm_hi_m;

	// Ramp state mirror
	logic [DW-1:0]  target_m;
	logic [DW-1:0]  ramp_m;
	logic [1:0]     leds_m;

	msmss_pkg::msmss_out_t  duty_forecast[$];
	int                     n_mismatch = 0;
	int                     burst_left = 0;
	bit                     hold_req = 1'b0;

	motor_speed_map_soft_start u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.push     (push),
		.full     (full),
		.item     (item),
		.empty    (empty),
		.pop      (pop),
		.result   (result)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Map a sample onto the duty range and advance the ramp on ticks
	function automatic msmss_pkg::msmss_out_t advance_motor(msmss_pkg::msmss_in_t b);
		int unsigned x, span, ofs, from, to;
		msmss_pkg::msmss_out_t r;
		if (b.action == ACT_SAMPLE) begin
			if (b.sample <= thresh_m) begin
				target_m = '0;
				leds_m = 2'b00;
			end else begin
				leds_m = b.jumper_closed ? 2'b10 : 2'b01;
				if (pot_hi_m <= pot_lo_m) begin
					target_m = pwm_lo_m;
				end else begin
					x = b.sample;
					if (x >= pot_hi_m) x = pot_hi_m;
					else if (x <= pot_lo_m) x = pot_lo_m;
					span = pot_hi_m - pot_lo_m;
					ofs = x - pot_lo_m;
					from = b.jumper_closed ? pwm_hi_m : pwm_lo_m;
					to = b.jumper_closed ? pwm_lo_m : pwm_hi_m;
					if (to >= from) target_m = DW'(from + ofs * (to - from) / span);
					else target_m = DW'(from - ofs * (from - to) / span);
				end
			end
		end else begin
			if (ramp_m < target_m) ramp_m++;
			else if (ramp_m > target_m) ramp_m--;
		end
		r.duty = ramp_m;
		r.led_direct = leds_m[0];
		r.led_inverted = leds_m[1];
		r.at_target = (ramp_m == target_m);
		return r;
	endfunction

	function automatic msmss_pkg::msmss_in_t mk_sample(int unsigned s, bit inv);
		msmss_pkg::msmss_in_t b;
		b.action = ACT_SAMPLE;
		b.sample = SW'(s);
		b.jumper_closed = inv;
		return b;
	endfunction

	// Tick with junk in the ignored fields
	function automatic msmss_pkg::msmss_in_t mk_tick();
		msmss_pkg::msmss_in_t b;
		b.action = ACT_TICK;
		b.sample = SW'($urandom_range(0, 255));
		b.jumper_closed = 1'($urandom_range(0, 1));
		return b;
	endfunction

	function automatic int unsigned pick_level();
		case ($urandom_range(0, 5))
			0: begin
				return 0;
			end
			1: begin
				return 255;
			end
			default: begin
				return $urandom_range(0, 255);
			end
		endcase
	endfunction

	// Offer one beat, idling between bursts, and log its prediction
	task automatic send_beat(input msmss_pkg::msmss_in_t b);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				push <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 16);
		end
		push <= 1'b1;
		item <= b;
		do @(posedge clk); while (full);
		duty_forecast.push_back(advance_motor(b));
		burst_left--;
	endtask

	// Stop offering and wait until every result has come back
	task automatic wait_drained();
		push <= 1'b0;
		burst_left = 0;
		do @(posedge clk); while (duty_forecast.size() != 0);
	endtask

	task automatic write_setting(input logic [IW-1:0] idx, input int unsigned val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= DW'(val);
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			msmss_pkg::CFG_OFF_THRESHOLD: thresh_m = DW'(val);
			msmss_pkg::CFG_POT_LOW:       pot_lo_m = DW'(val);
			msmss_pkg::CFG_POT_HIGH:      pot_hi_m = DW'(val);
			msmss_pkg::CFG_PWM_LOW:       pwm_lo_m = DW'(val);
			msmss_pkg::CFG_PWM_HIGH:      pwm_hi_m = DW'(val);
			default: ;
		endcase
	endtask

	task automatic write_all(input int unsigned th, plo, phi, wlo, whi);
		write_setting(msmss_pkg::CFG_OFF_THRESHOLD, th);
		write_setting(msmss_pkg::CFG_POT_LOW, plo);
		write_setting(msmss_pkg::CFG_POT_HIGH, phi);
		write_setting(msmss_pkg::CFG_PWM_LOW, wlo);
		write_setting(msmss_pkg::CFG_PWM_HIGH, whi);
	endtask

	// Compare one accepted result beat with the oldest prediction
	task automatic check_beat(input msmss_pkg::msmss_out_t got);
		msmss_pkg::msmss_out_t want;
		if (duty_forecast.size() == 0) begin
			n_mismatch++;
			$display("%0t: result beat with none expected, actual duty %0d leds %b%b at %b",
				$time, got.duty, got.led_inverted, got.led_direct, got.at_target);
		end else begin
			want = duty_forecast.pop_front();
			if (got.duty !== want.duty) begin
				n_mismatch++;
				$display("%0t: duty expected %0d actual %0d", $time, want.duty, got.duty);
			end
			if (got.led_direct !== want.led_direct) begin
				n_mismatch++;
				$display("%0t: led_direct expected %b actual %b", $time,
					want.led_direct, got.led_direct);
			end
			if (got.led_inverted !== want.led_inverted) begin
				n_mismatch++;
				$display("%0t: led_inverted expected %b actual %b", $time,
					want.led_inverted, got.led_inverted);
			end
			if (got.at_target !== want.at_target) begin
				n_mismatch++;
				$display("%0t: at_target expected %b actual %b", $time,
					want.at_target, got.at_target);
			end
		end
	endtask

	// Result sink: check each beat, stall on a shifting pattern, honor hold-offs
	initial begin : result_sink
		int cyc, mode, hold_left;
		cyc = 0;
		mode = 0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (arst_n && pop && !empty) check_beat(result);
			if (cyc % 64 == 0) mode = $urandom_range(0, 2);
			cyc++;
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				pop <= 1'b0;
			end else begin
				case (mode)
					0: pop <= 1'b1;
					1: pop <= ($urandom_range(0, 3) != 0);
					default: pop <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	// Watchdog: end the run when no beat moves for too long
	initial begin : watchdog
		int quiet;
		quiet = 0;
		forever begin
			@(posedge clk);
			if ((push && !full) || (pop && !empty) || !arst_n) quiet = 0;
			else quiet++;
			if (quiet >= IDLE_LIMIT) begin
				$display("testbench failed");
				$finish;
			end
		end
	end

	// Default settings: stop samples, window ends, ramp, ticks at target
	task automatic test_reset_values();
		send_beat(mk_tick());
		send_beat(mk_sample(0, 1'b0));
		send_beat(mk_sample(10, 1'b1));
		send_beat(mk_sample(11, 1'b0));
		send_beat(mk_tick());
		send_beat(mk_sample(255, 1'b1));
		send_beat(mk_tick());
		send_beat(mk_sample(70, 1'b0));
		send_beat(mk_sample(235, 1'b0));
		wait_drained();
	endtask

	// Writes to unused indexes change nothing
	task automatic test_unused_index();
		for (int i = int'(msmss_pkg::CFG_PWM_HIGH) + 1; i < (1 << IW); i++)
			write_setting(IW'(i), $urandom_range(0, 255));
		send_beat(mk_sample(150, 1'b0));
		send_beat(mk_tick());
		wait_drained();
	endtask

	// Pot window with no width, then reversed
	task automatic test_empty_window();
		write_all(5, 128, 128, 40, 220);
		send_beat(mk_sample(200, 1'b1));
		send_beat(mk_tick());
		wait_drained();
		write_all(5, 200, 50, 40, 220);
		send_beat(mk_sample(255, 1'b0));
		wait_drained();
	endtask

	// Duty range that falls with the sample
	task automatic test_reversed_range();
		write_all(0, 0, 255, 200, 3);
		send_beat(mk_sample(1, 1'b0));
		send_beat(mk_sample(100, 1'b1));
		send_beat(mk_sample(255, 1'b0));
		wait_drained();
	endtask

	// All registers at zero, then all at full scale
	task automatic test_register_extremes();
		write_all(0, 0, 0, 0, 0);
		send_beat(mk_sample(0, 1'b0));
		send_beat(mk_sample(255, 1'b1));
		wait_drained();
		write_all(255, 255, 255, 255, 255);
		send_beat(mk_sample(255, 1'b0));
		wait_drained();
	endtask

	// Random settings per phase; mostly a sample followed by a run of ticks
	task automatic test_random_phases();
		int n, wlo, whi, plo, phi;
		for (int ph = 0; ph < 8; ph++) begin
			wlo = pick_level();
			whi = ($urandom_range(0, 1) == 0) ? pick_level()
				: (wlo + $urandom_range(0, 12)) % 256;
			plo = pick_level();
			phi = ($urandom_range(0, 3) == 0) ? pick_level()
				: plo + $urandom_range(0, 255 - plo);
			write_all(($urandom_range(0, 1) == 0) ? pick_level() : $urandom_range(0, 30),
				plo, phi, wlo, whi);
			n = 0;
			while (n < 45) begin
				if ($urandom_range(0, 3) != 0) begin
					send_beat(mk_sample($urandom_range(0, 255), 1'($urandom_range(0, 1))));
					n++;
					repeat ($urandom_range(0, 14)) begin
						send_beat(mk_tick());
						n++;
					end
				end else if ($urandom_range(0, 1) == 0) begin
					send_beat(mk_tick());
					n++;
				end else begin
					send_beat(mk_sample(pick_level(), 1'($urandom_range(0, 1))));
					n++;
				end
			end
			wait_drained();
		end
	endtask

	// Hold the receiver off while beats keep coming, so the input stalls
	task automatic test_receiver_hold();
		write_all(10, 70, 235, 1, 255);
		hold_req = 1'b1;
		burst_left = 40;
		repeat (30) begin
			if ($urandom_range(0, 1) == 0) send_beat(mk_tick());
			else send_beat(mk_sample($urandom_range(0, 255), 1'($urandom_range(0, 1))));
		end
		wait_drained();
	endtask

	initial begin : stimulus
		thresh_m = msmss_pkg::RST_OFF_THRESHOLD;
		pot_lo_m = msmss_pkg::RST_POT_LOW;
		pot_hi_m = msmss_pkg::RST_POT_HIGH;
		pwm_lo_m = msmss_pkg::RST_PWM_LOW;
		pwm_hi_m = msmss_pkg::RST_PWM_HIGH;
		target_m = '0;
		ramp_m = '0;
		leds_m = 2'b00;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_values();
		test_unused_index();
		test_empty_window();
		test_reversed_range();
		test_register_extremes();
		test_random_phases();
		test_receiver_hold();

		wait_drained();
		repeat (40) @(posedge clk);
		if (n_mismatch == 0) begin
			$display("testbench passed");
		end else begin
			$display("testbench failed");
		end
		$finish;
	end

endmodule
